FILE: src/mmu_context_lru_allocator_top_macros.svh
// Assertion helpers used by the bound checker module.
`ifndef MMU_CONTEXT_LRU_ALLOCATOR_TOP_MACROS_SVH
`define MMU_CONTEXT_LRU_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MMU_CTX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MMU_CTX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/mmu_ctx_pkg.sv
package mmu_ctx_pkg;

  localparam int NUM_CONTEXTS_DEF = 8;

  localparam int FUNC_W  = 2;
  localparam int OWNER_W = 8;
  localparam int CIDX_W  = 3;

  localparam logic [FUNC_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] OP_TOUCH = 2'd1;
  localparam logic [FUNC_W-1:0] OP_FREE  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [OWNER_W-1:0] owner_id;
    logic [CIDX_W-1:0]  context_index;
  } in_item_t;

  typedef struct packed {
    logic [CIDX_W-1:0]  context_num;
    logic               evicted;
    logic [OWNER_W-1:0] evicted_owner;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic unlink;
    logic link;
    logic put;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic list_op;
  } dp_stat_t;

endpackage

FILE: src/mmu_ctx_dp.sv
module mmu_ctx_dp #(
  parameter int NUM_CONTEXTS = mmu_ctx_pkg::NUM_CONTEXTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mmu_ctx_pkg::ctrl_cmd_t cmd,
  output mmu_ctx_pkg::dp_stat_t  stat,
  input  mmu_ctx_pkg::in_item_t  in_data,
  output mmu_ctx_pkg::out_item_t out_data
);
  import mmu_ctx_pkg::*;

  localparam int IW = $clog2(NUM_CONTEXTS);

  logic [IW-1:0]      next_r  [NUM_CONTEXTS];
  logic [IW-1:0]      prev_r  [NUM_CONTEXTS];
  logic [OWNER_W-1:0] owner_r [NUM_CONTEXTS];
  logic [NUM_CONTEXTS-1:0] used_r;
  logic [IW-1:0]      head_r;
  logic [IW-1:0]      tail_r;

  in_item_t  req_r;
  out_item_t res_r;
  out_item_t out_r;
  logic [IW-1:0] p_r;
  logic [IW-1:0] n_r;

  logic [IW-1:0] c;
  logic          idx_ok;
  logic          is_alloc;
  logic          is_touch;
  logic          is_free;

  assign c        = IW'(req_r.context_index);
  assign idx_ok   = int'(req_r.context_index) < NUM_CONTEXTS;
  assign is_alloc = (req_r.func == OP_ALLOC);
  assign is_touch = (req_r.func == OP_TOUCH);
  assign is_free  = (req_r.func == OP_FREE);

  assign stat.list_op = idx_ok && (is_touch || is_free);
  assign out_data     = out_r;

  // list links, head/tail and used marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CONTEXTS; i++) begin
        next_r[i] <= IW'((i + 1) % NUM_CONTEXTS);
        prev_r[i] <= IW'((i + NUM_CONTEXTS - 1) % NUM_CONTEXTS);
      end
      used_r <= '0;
      head_r <= '0;
      tail_r <= IW'(NUM_CONTEXTS - 1);
    end else begin
      if (cmd.exec && is_alloc) begin
        used_r[head_r] <= 1'b1;
      end
      if (cmd.unlink) begin
        if (c == head_r) begin
          head_r <= n_r;
        end else begin
          next_r[p_r] <= n_r;
        end
        if (c == tail_r) begin
          tail_r <= p_r;
        end else begin
          prev_r[n_r] <= p_r;
        end
      end
      if (cmd.link) begin
        if (is_touch) begin
          next_r[tail_r] <= c;
          prev_r[c]      <= tail_r;
          tail_r         <= c;
        end else begin
          prev_r[head_r] <= c;
          next_r[c]      <= head_r;
          head_r         <= c;
          used_r[c]      <= 1'b0;
        end
      end
    end
  end

  // payload: request, neighbors, owners, result and output beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.exec) begin
      p_r <= prev_r[c];
      n_r <= next_r[c];
      if (is_alloc) begin
        owner_r[head_r]     <= req_r.owner_id;
        res_r.context_num   <= CIDX_W'(head_r);
        res_r.evicted       <= used_r[head_r];
        res_r.evicted_owner <= used_r[head_r] ? owner_r[head_r] : '0;
      end else begin
        res_r.context_num   <= req_r.context_index;
        res_r.evicted       <= 1'b0;
        res_r.evicted_owner <= '0;
      end
    end
    if (cmd.put) begin
      out_r <= res_r;
    end
  end

endmodule

FILE: src/mmu_ctx_ctrl.sv
module mmu_ctx_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mmu_ctx_pkg::ctrl_cmd_t cmd,
  input  mmu_ctx_pkg::dp_stat_t  stat
);
  import mmu_ctx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UNLINK,
    S_LINK,
    S_PUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.list_op ? S_UNLINK : S_PUT;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt  = S_LINK;
      end
      S_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        // hold until the previous beat has left the output register
        if (slot_free) begin
          cmd.put       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/mmu_context_lru_allocator_top.sv
// MMU context allocator, LRU order kept as a doubly linked list.
// Input channel in_valid/in_stall/in_data carries one request per beat:
// allocate takes the head context, touch moves a context to the MRU tail,
// free clears its used mark and moves it to the head.
// Output channel out_valid/out_stall/out_data returns one beat per request:
// granted or echoed context, evicted flag and the evicted owner.
// Steps from the accepting edge to out_valid: execute, then put for allocate
// and invalid requests; touch and free add unlink and relink in between. The
// sequencer handles one request at a time, so a new request is taken only
// after the last one has been put; the unlink and relink steps each make at
// most one write into the next-link and prev-link register files.
// The output register holds a finished beat; the next request may be
// accepted while it waits. If out_stall is still high when the following
// result is ready, the sequencer holds in its final step and in_stall stays
// high until the output register drains.
// Reset (rst_n low, synchronous) frees every context and puts the list in
// numeric order with context 0 at the head.
module mmu_context_lru_allocator_top #(
  parameter int NUM_CONTEXTS = mmu_ctx_pkg::NUM_CONTEXTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  mmu_ctx_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mmu_ctx_pkg::out_item_t out_data
);
  import mmu_ctx_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mmu_ctx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  mmu_ctx_dp #(
    .NUM_CONTEXTS (NUM_CONTEXTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

FILE: src/mmu_ctx_chk.sv
`include "mmu_context_lru_allocator_top_macros.svh"

module mmu_ctx_chk (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input mmu_ctx_pkg::in_item_t  in_data,
  input logic                   out_valid,
  input logic                   out_stall,
  input mmu_ctx_pkg::out_item_t out_data
);
  import mmu_ctx_pkg::*;

  // a stalled beat stays put
  `MMU_CTX_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "output beat changed while stalled")

  // one request in flight at a time
  `MMU_CTX_ASSERT_NEXT(a_single, in_valid && !in_stall, in_stall, "second request taken while busy")

  // a new result only comes out of a request being worked on
  `MMU_CTX_ASSERT_NOW(a_out_src, $rose(out_valid), $past(in_stall), "output beat with no request in flight")

  // no eviction, no owner reported
  `MMU_CTX_ASSERT_NOW(a_owner_zero, out_valid && !out_data.evicted, out_data.evicted_owner == '0, "owner reported without eviction")

endmodule

bind mmu_context_lru_allocator_top mmu_ctx_chk u_chk (.*);

FILE: sim/mmu_context_lru_allocator_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow copy of the LRU list and compares
// every result beat against the expected grant.
module mmu_context_lru_allocator_checker
  import mmu_ctx_pkg::*;
#(
  parameter int NUM_CTX = NUM_CONTEXTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        mismatches,
  output int        waiting
);

  logic [CIDX_W-1:0]  fwd [NUM_CTX];
  logic [CIDX_W-1:0]  bwd [NUM_CTX];
  logic [CIDX_W-1:0]  head;
  logic [CIDX_W-1:0]  tail;
  logic               in_use [NUM_CTX];
  logic [OWNER_W-1:0] holder [NUM_CTX];

  out_item_t pending_resp [$];

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void unlink(int c);
    int p;
    int n;
    p = bwd[c];
    n = fwd[c];
    if (c == head) head = CIDX_W'(n);
    else fwd[p] = CIDX_W'(n);
    if (c == tail) tail = CIDX_W'(p);
    else bwd[n] = CIDX_W'(p);
  endfunction

  function automatic out_item_t next_response(in_item_t req);
    out_item_t r;
    int c;
    r = '0;
    c = req.context_index;
    r.context_num = req.context_index;
    case (req.func)
      OP_ALLOC: begin
        // grant the head; order is left alone
        r.context_num = head;
        if (in_use[head]) begin
          r.evicted = 1'b1;
          r.evicted_owner = holder[head];
        end
        in_use[head] = 1'b1;
        holder[head] = req.owner_id;
      end
      OP_TOUCH: begin
        if (c < NUM_CTX) begin
          unlink(c);
          fwd[tail] = CIDX_W'(c);
          bwd[c] = tail;
          tail = CIDX_W'(c);
        end
      end
      OP_FREE: begin
        if (c < NUM_CTX) begin
          in_use[c] = 1'b0;
          unlink(c);
          bwd[head] = CIDX_W'(c);
          fwd[c] = head;
          head = CIDX_W'(c);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_CTX; i++) begin
        fwd[i] = CIDX_W'((i + 1) % NUM_CTX);
        bwd[i] = CIDX_W'((i + NUM_CTX - 1) % NUM_CTX);
        in_use[i] = 1'b0;
        holder[i] = '0;
      end
      head = '0;
      tail = CIDX_W'(NUM_CTX - 1);
      pending_resp.delete();
    end else begin
      // results leave before new requests are modeled; a result never leaves in the cycle its request is taken
      if (out_valid && !out_stall) begin
        if (pending_resp.size() == 0) begin
          report("unexpected beat, context_num", out_data.context_num, 0);
        end else begin
          want = pending_resp.pop_front();
          if (out_data.context_num !== want.context_num)
            report("context_num", out_data.context_num, want.context_num);
          if (out_data.evicted !== want.evicted)
            report("evicted", out_data.evicted, want.evicted);
          if (out_data.evicted_owner !== want.evicted_owner)
            report("evicted_owner", out_data.evicted_owner, want.evicted_owner);
        end
      end
      if (in_valid && !in_stall) pending_resp.push_back(next_response(in_data));
    end
    waiting <= pending_resp.size();
  end

endmodule

FILE: sim/mmu_context_lru_allocator_top_test.sv
`timescale 1ns / 1ps

module mmu_context_lru_allocator_top_test;
  import mmu_ctx_pkg::*;

  localparam logic [FUNC_W-1:0] OP_NONE = 2'd3;
  localparam int RANDOM_REQS  = 400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 120;
  localparam int HOLD_AT_BEAT = 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int mismatches;
  int waiting;
  int cycles;
  int sent;
  bit send_busy;

  mmu_context_lru_allocator_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  mmu_context_lru_allocator_checker chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .mismatches(mismatches),
    .waiting(waiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one request beat; returns at the accepting edge
  task automatic issue(input logic [FUNC_W-1:0] f, input logic [OWNER_W-1:0] o,
                       input logic [CIDX_W-1:0] c);
    int gap;
    if (sent % 32 == 0) send_busy = 1'($urandom_range(0, 1));
    gap = send_busy ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{func: f, owner_id: o, context_index: c};
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // waiting is registered behind the queue, so always wait for a clock edge before checking it
  task automatic wait_drained();
    do @(posedge clk); while (waiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random stall per beat, quiet stretches, one long hold-off
  initial begin
    int n_seen;
    int gap;
    bit recv_busy;
    n_seen = 0;
    recv_busy = 1'b0;
    out_stall <= 1'b0;
    forever begin
      if (n_seen % 32 == 0) recv_busy = 1'($urandom_range(0, 1));
      gap = recv_busy ? $urandom_range(0, 11) : 0;
      if (n_seen == HOLD_AT_BEAT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      n_seen++;
    end
  end

  initial begin
    int pick;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(OP_ALLOC, 8'h00, 3'd7);  // free head, index ignored
    issue(OP_ALLOC, 8'hFF, 3'd0);  // same head again, now evicts
    issue(OP_TOUCH, 8'h00, 3'd0);  // head moves to tail
    issue(OP_ALLOC, 8'h5A, 3'd3);
    issue(OP_TOUCH, 8'hFF, 3'd0);  // already tail
    issue(OP_TOUCH, 8'h00, 3'd1);
    issue(OP_FREE,  8'h00, 3'd2);  // head, already free
    issue(OP_FREE,  8'h00, 3'd5);  // free entry still moves to head
    issue(OP_ALLOC, 8'hA5, 3'd0);
    issue(OP_FREE,  8'h00, 3'd1);  // used entry back to head
    issue(OP_ALLOC, 8'h01, 3'd4);
    issue(OP_FREE,  8'hFF, 3'd1);  // free of head while used
    issue(OP_ALLOC, 8'h80, 3'd0);
    issue(OP_FREE,  8'h00, 3'd7);
    issue(OP_NONE,  8'hFF, 3'd7);
    issue(OP_NONE,  8'h00, 3'd0);
    issue(OP_ALLOC, 8'h7F, 3'd2);
    issue(OP_TOUCH, 8'h00, 3'd7);
    issue(OP_ALLOC, 8'h3C, 3'd6);
    for (int i = 0; i < 6; i++) begin
      issue(OP_TOUCH, 8'h00, 3'(i));
      issue(OP_ALLOC, 8'(8'hC0 + i), 3'(7 - i));
    end
    in_valid <= 1'b0;
    wait_drained();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        issue(OP_ALLOC, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      else if (pick < 70)
        issue(OP_TOUCH, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      else if (pick < 93)
        issue(OP_FREE, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      else
        issue(OP_NONE, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      if (n == RANDOM_REQS / 2) begin
        in_valid <= 1'b0;
        wait_drained();
      end
    end
    in_valid <= 1'b0;
    wait_drained();

    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

FILE: mmu_context_lru_allocator_top.f
+incdir+src
src/mmu_ctx_pkg.sv
src/mmu_ctx_dp.sv
src/mmu_ctx_ctrl.sv
src/mmu_context_lru_allocator_top.sv
src/mmu_ctx_chk.sv
sim/mmu_context_lru_allocator_checker.sv
sim/mmu_context_lru_allocator_top_test.sv
